// ===== hdl/ita_pkg.sv =====
// Shared types, codes and character helpers for the integer to ASCII formatter.
package ita_pkg;

    localparam int unsigned ValueWidth = 64;
    localparam int unsigned WordWidth  = 32;
    localparam int unsigned BcdDigits  = 10;
    localparam int unsigned BcdWidth   = 4 * BcdDigits;
    localparam int unsigned CountWidth = 5;

    localparam logic [2:0] KIND_SDEC  = 3'd0;
    localparam logic [2:0] KIND_UDEC  = 3'd1;
    localparam logic [2:0] KIND_HEX_L = 3'd2;
    localparam logic [2:0] KIND_HEX_U = 3'd3;
    localparam logic [2:0] KIND_PTR   = 3'd4;

    localparam logic [CountWidth-1:0] CNT_PTR = 5'd16;
    localparam logic [CountWidth-1:0] CNT_HEX = 5'd8;
    localparam logic [CountWidth-1:0] CNT_DEC = 5'd10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SKIP,
        ST_PREFIX,
        ST_DIGITS
    } state_t;

    typedef enum logic [1:0] {
        PFX_NONE,
        PFX_MINUS,
        PFX_HEX,
        PFX_NIL
    } pfx_t;

    typedef struct packed {
        logic load;
        logic shift;
    } ita_dig_ctrl_t;

    function automatic logic [2:0] pfx_len(input pfx_t pfx);
        logic [2:0] len;
        case (pfx)
            PFX_MINUS: len = 3'd1;
            PFX_HEX:   len = 3'd2;
            PFX_NIL:   len = 3'd5;
            default:   len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] pfx_char(input pfx_t pfx, input logic [2:0] idx);
        logic [7:0] ch;
        ch = 8'h30;
        case (pfx)
            PFX_MINUS: ch = 8'h2d;
            PFX_HEX:   ch = (idx == 3'd0) ? 8'h30 : 8'h78;
            PFX_NIL:
            begin
                case (idx)
                    3'd0:    ch = 8'h28;
                    3'd1:    ch = 8'h6e;
                    3'd2:    ch = 8'h69;
                    3'd3:    ch = 8'h6c;
                    default: ch = 8'h29;
                endcase
            end
            default:   ch = 8'h30;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
        logic [7:0] ch;
        if (nib < 4'd10)
        begin
            ch = 8'h30 + {4'b0, nib};
        end
        else
        begin
            ch = (upper ? 8'h41 : 8'h61) + {4'b0, nib} - 8'd10;
        end
        return ch;
    endfunction

endpackage

// ===== hdl/ita_bcd.sv =====
// Bit-serial binary to BCD converter using shift-and-add-three, one bit per cycle.
module ita_bcd (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [ita_pkg::WordWidth-1:0]      bin,
    output logic                               done,
    output logic [ita_pkg::BcdWidth-1:0]       bcd
);

    logic [ita_pkg::WordWidth-1:0] bin_reg;
    logic [ita_pkg::WordWidth-1:0] bin_next;
    logic [ita_pkg::BcdWidth-1:0]  bcd_reg;
    logic [ita_pkg::BcdWidth-1:0]  bcd_next;
    logic [ita_pkg::BcdWidth-1:0]  adj;
    logic [5:0]                    cnt_reg;
    logic [5:0]                    cnt_next;
    logic                          done_reg;
    logic                          done_next;

    always_comb
    begin
        for (int i = 0; i < ita_pkg::BcdDigits; i++)
        begin
            adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ? bcd_reg[4*i +: 4] + 4'd3
                                                        : bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            bin_next = bin;
            bcd_next = '0;
            cnt_next = 6'(ita_pkg::WordWidth);
        end
        else if (cnt_reg != 6'd0)
        begin
            bin_next  = {bin_reg[ita_pkg::WordWidth-2:0], 1'b0};
            bcd_next  = {adj[ita_pkg::BcdWidth-2:0], bin_reg[ita_pkg::WordWidth-1]};
            cnt_next  = cnt_reg - 6'd1;
            done_next = (cnt_reg == 6'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

// ===== hdl/ita_digits.sv =====
// Digit shift register that presents one nibble at a time, most significant first.
module ita_digits (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ita_pkg::ita_dig_ctrl_t               ctrl,
    input  logic [ita_pkg::ValueWidth-1:0]       load_data,
    input  logic [ita_pkg::CountWidth-1:0]       load_count,
    output logic [3:0]                           top_nibble,
    output logic [ita_pkg::CountWidth-1:0]       count
);

    logic [ita_pkg::ValueWidth-1:0] dig_reg;
    logic [ita_pkg::ValueWidth-1:0] dig_next;
    logic [ita_pkg::CountWidth-1:0] cnt_reg;
    logic [ita_pkg::CountWidth-1:0] cnt_next;

    always_comb
    begin
        dig_next = dig_reg;
        cnt_next = cnt_reg;
        if (ctrl.load)
        begin
            dig_next = load_data;
            cnt_next = load_count;
        end
        else if (ctrl.shift)
        begin
            dig_next = {dig_reg[ita_pkg::ValueWidth-5:0], 4'b0};
            cnt_next = cnt_reg - 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg <= dig_next;
    end

    assign top_nibble = dig_reg[ita_pkg::ValueWidth-1 -: 4];
    assign count      = cnt_reg;

endmodule

// ===== hdl/integer_to_ascii_formatter.sv =====
// Top level of the integer to ASCII formatter: sequencer and output register.
//
// An input word carries a number in s_axis_tdata and a format kind in s_axis_tuser:
// signed decimal, unsigned decimal, lowercase hex, uppercase hex or a 64-bit pointer.
// The text of the number leaves on the master side one character per word, most
// significant first, with m_axis_tlast on its final character.
// Hex and pointer numbers are loaded straight into a nibble shift register. Decimal
// numbers first pass through a bit-serial BCD converter. Leading zero digits are
// then dropped one per cycle, after which the prefix ("-", "0x" or "(nil)") and
// the digits leave at one character per cycle while the output register is free.
// One number is in work at a time; the next is accepted once the final character
// has entered the output register, even while it still waits. When the receiver
// holds m_axis_tready low, the output register keeps its word and the sequencer
// waits before it emits another character. Reset empties the output register and
// returns to idle.
module integer_to_ascii_formatter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // value[63:0]
    input  logic [2:0]  s_axis_tuser,   // kind[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // char_out[7:0]
    output logic        m_axis_tlast
);

    ita_pkg::state_t state_reg;
    ita_pkg::state_t state_next;
    ita_pkg::pfx_t   pfx_reg;
    ita_pkg::pfx_t   pfx_next;
    logic            upper_reg;
    logic            upper_next;
    logic [2:0]      pidx_reg;
    logic [2:0]      pidx_next;
    logic            m_valid_reg;
    logic            m_valid_next;
    logic [7:0]      m_data_reg;
    logic [7:0]      m_data_next;
    logic            m_last_reg;
    logic            m_last_next;

    logic                                 accept;
    logic                                 out_free;
    logic [ita_pkg::WordWidth-1:0]        low;
    logic [ita_pkg::WordWidth-1:0]        mag;
    logic                                 is_ptr;
    logic                                 is_hex;
    logic                                 is_dec;
    logic                                 neg;
    logic                                 ptr_nil;
    ita_pkg::pfx_t                        in_pfx;

    logic                                 bcd_start;
    logic                                 bcd_done;
    logic [ita_pkg::BcdWidth-1:0]         bcd;

    ita_pkg::ita_dig_ctrl_t               dig_ctrl;
    logic [ita_pkg::ValueWidth-1:0]       dig_load_data;
    logic [ita_pkg::CountWidth-1:0]       dig_load_count;
    logic [3:0]                           top_nibble;
    logic [ita_pkg::CountWidth-1:0]       dig_count;

    logic                                 emit;
    logic [7:0]                           emit_char;
    logic                                 emit_last;
    logic                                 skip_more;
    logic                                 pfx_end;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_valid_reg || m_axis_tready;

    assign low     = s_axis_tdata[ita_pkg::WordWidth-1:0];
    assign is_ptr  = (s_axis_tuser == ita_pkg::KIND_PTR);
    assign is_hex  = (s_axis_tuser == ita_pkg::KIND_HEX_L) ||
                     (s_axis_tuser == ita_pkg::KIND_HEX_U);
    assign is_dec  = !is_ptr && !is_hex;
    assign neg     = (s_axis_tuser == ita_pkg::KIND_SDEC) && low[ita_pkg::WordWidth-1];
    assign mag     = neg ? (ita_pkg::WordWidth'(0) - low) : low;
    assign ptr_nil = is_ptr && (s_axis_tdata == '0);

    always_comb
    begin
        if (ptr_nil)
        begin
            in_pfx = ita_pkg::PFX_NIL;
        end
        else if (is_ptr)
        begin
            in_pfx = ita_pkg::PFX_HEX;
        end
        else if (neg)
        begin
            in_pfx = ita_pkg::PFX_MINUS;
        end
        else
        begin
            in_pfx = ita_pkg::PFX_NONE;
        end
    end

    assign skip_more = (top_nibble == 4'd0) && (dig_count > 5'd1);
    assign pfx_end   = (pidx_reg == (ita_pkg::pfx_len(pfx_reg) - 3'd1));

    ita_bcd u_bcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (bcd_start),
        .bin   (mag),
        .done  (bcd_done),
        .bcd   (bcd)
    );

    ita_digits u_digits (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (dig_ctrl),
        .load_data  (dig_load_data),
        .load_count (dig_load_count),
        .top_nibble (top_nibble),
        .count      (dig_count)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ita_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (ptr_nil)
                    begin
                        state_next = ita_pkg::ST_PREFIX;
                    end
                    else if (is_dec)
                    begin
                        state_next = ita_pkg::ST_CONVERT;
                    end
                    else
                    begin
                        state_next = ita_pkg::ST_SKIP;
                    end
                end
            end
            ita_pkg::ST_CONVERT:
            begin
                if (bcd_done)
                begin
                    state_next = ita_pkg::ST_SKIP;
                end
            end
            ita_pkg::ST_SKIP:
            begin
                if (!skip_more)
                begin
                    state_next = (pfx_reg == ita_pkg::PFX_NONE) ? ita_pkg::ST_DIGITS
                                                                : ita_pkg::ST_PREFIX;
                end
            end
            ita_pkg::ST_PREFIX:
            begin
                if (out_free && pfx_end)
                begin
                    state_next = (pfx_reg == ita_pkg::PFX_NIL) ? ita_pkg::ST_IDLE
                                                               : ita_pkg::ST_DIGITS;
                end
            end
            ita_pkg::ST_DIGITS:
            begin
                if (out_free && (dig_count == 5'd1))
                begin
                    state_next = ita_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ita_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_axis_tready  = 1'b0;
        bcd_start      = 1'b0;
        dig_ctrl       = '0;
        dig_load_data  = {low, {ita_pkg::WordWidth{1'b0}}};
        dig_load_count = ita_pkg::CNT_HEX;
        emit           = 1'b0;
        emit_char      = ita_pkg::digit_char(top_nibble, upper_reg);
        emit_last      = 1'b0;
        pfx_next       = pfx_reg;
        upper_next     = upper_reg;
        pidx_next      = pidx_reg;
        case (state_reg)
            ita_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (accept)
                begin
                    pfx_next      = in_pfx;
                    upper_next    = (s_axis_tuser == ita_pkg::KIND_HEX_U);
                    pidx_next     = 3'd0;
                    bcd_start     = is_dec;
                    dig_ctrl.load = !is_dec;
                    if (is_ptr)
                    begin
                        dig_load_data  = s_axis_tdata;
                        dig_load_count = ita_pkg::CNT_PTR;
                    end
                end
            end
            ita_pkg::ST_CONVERT:
            begin
                dig_load_data  = {bcd, {(ita_pkg::ValueWidth - ita_pkg::BcdWidth){1'b0}}};
                dig_load_count = ita_pkg::CNT_DEC;
                dig_ctrl.load  = bcd_done;
            end
            ita_pkg::ST_SKIP:
            begin
                dig_ctrl.shift = skip_more;
            end
            ita_pkg::ST_PREFIX:
            begin
                emit_char = ita_pkg::pfx_char(pfx_reg, pidx_reg);
                emit_last = (pfx_reg == ita_pkg::PFX_NIL) && pfx_end;
                if (out_free)
                begin
                    emit      = 1'b1;
                    pidx_next = pidx_reg + 3'd1;
                end
            end
            ita_pkg::ST_DIGITS:
            begin
                emit_last = (dig_count == 5'd1);
                if (out_free)
                begin
                    emit           = 1'b1;
                    dig_ctrl.shift = 1'b1;
                end
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        if (emit)
        begin
            m_valid_next = 1'b1;
            m_data_next  = emit_char;
            m_last_next  = emit_last;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ita_pkg::ST_IDLE;
            pfx_reg     <= ita_pkg::PFX_NONE;
            upper_reg   <= 1'b0;
            pidx_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pfx_reg     <= pfx_next;
            upper_reg   <= upper_next;
            pidx_reg    <= pidx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule

// ===== hdl/ita_checker.sv =====
// Port-level checker for the integer to ASCII formatter, bound to the top level.
module ita_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tlast
);

    // A stalled word stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word withdrawn while stalled");

    // A stalled word keeps its character and end mark.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    // Once a number is taken, the block is busy with it in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken again straight after acceptance");

    // A character that is not the last of its text means a number is still in work.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input ready in the middle of a text");

endmodule

bind integer_to_ascii_formatter ita_checker u_ita_checker (.*);

// ===== tb/ita_text_check.sv =====
// Stream monitor that predicts the formatted text of each number and compares it word by word.
module ita_text_check (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // value[63:0]
    input  logic [2:0]  s_axis_tuser,   // kind[2:0]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,   // char_out[7:0]
    input  logic        m_axis_tlast,
    output int unsigned mismatches,
    output int unsigned outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] ASC_ZERO  = "0";
    localparam logic [7:0] ASC_LOWER = "a";
    localparam logic [7:0] ASC_UPPER = "A";
    localparam logic [7:0] ASC_MINUS = "-";
    localparam logic [7:0] ASC_X     = "x";

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    text_char_t expected_text[$];

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    function automatic void queue_text(input logic [7:0] text[$]);
        text_char_t entry;
        for (int i = 0; i < text.size(); i++)
        begin
            entry.ch   = text[i];
            entry.last = (i == text.size() - 1);
            expected_text.push_back(entry);
        end
    endfunction

    function automatic void format_number(input logic [2:0] kind, input logic [63:0] value);
        logic [7:0]  text[$];
        logic [7:0]  reversed[$];
        logic [63:0] n;
        logic [31:0] low;
        logic [3:0]  nib;
        int          radix;
        logic        upper;
        low   = value[31:0];
        radix = 10;
        upper = 1'b0;
        n     = {32'd0, low};
        if (kind == ita_pkg::KIND_PTR)
        begin
            if (value == 64'd0)
            begin
                text = '{"(", "n", "i", "l", ")"};
                queue_text(text);
                return;
            end
            text  = '{ASC_ZERO, ASC_X};
            n     = value;
            radix = 16;
        end
        else if (low == 32'd0)
        begin
            text = '{ASC_ZERO};
            queue_text(text);
            return;
        end
        else if (kind == ita_pkg::KIND_SDEC)
        begin
            if (low[31])
            begin
                text.push_back(ASC_MINUS);
                n = {32'd0, 32'd0 - low};
            end
        end
        else if (kind == ita_pkg::KIND_HEX_L || kind == ita_pkg::KIND_HEX_U)
        begin
            radix = 16;
            upper = (kind == ita_pkg::KIND_HEX_U);
        end
        while (n != 64'd0)
        begin
            nib = 4'(n % radix);
            if (nib < 4'd10)
                reversed.push_front(ASC_ZERO + 8'(nib));
            else
                reversed.push_front((upper ? ASC_UPPER : ASC_LOWER) + 8'(nib) - 8'd10);
            n = n / radix;
        end
        foreach (reversed[i])
            text.push_back(reversed[i]);
        queue_text(text);
    endfunction

    task automatic log_failure(input string msg);
        if (mismatches < 10)
            $display("%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        text_char_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_text.size() == 0)
                begin
                    log_failure($sformatf("unexpected word: char 0x%02h last %0b",
                                          m_axis_tdata, m_axis_tlast));
                end
                else
                begin
                    want = expected_text.pop_front();
                    if (m_axis_tdata !== want.ch || m_axis_tlast !== want.last)
                        log_failure($sformatf(
                            "mismatch: expected char 0x%02h last %0b, got char 0x%02h last %0b",
                            want.ch, want.last, m_axis_tdata, m_axis_tlast));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                format_number(s_axis_tuser, s_axis_tdata);
            outstanding = expected_text.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the testbench: clock, reset, number stimulus, receiver stalls and the verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;     // value[63:0]
    logic [2:0]  s_axis_tuser;     // kind[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;     // char_out[7:0]
    logic        m_axis_tlast;
    int unsigned mismatches;
    int unsigned outstanding;
    bit          quiet = 1'b0;

    integer_to_ascii_formatter u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    ita_text_check u_text_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #10ms;
        $display("testbench: errors");
        $finish;
    end

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    initial
    begin
        int hold;
        m_axis_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            m_axis_tready <= 1'b1;
            hold = $urandom_range(1, 16);
            repeat (hold - 1) @(negedge clk);
            hold = quiet ? 0 : draw_gap();
            if (hold > 0)
            begin
                @(negedge clk);
                m_axis_tready <= 1'b0;
                repeat (hold - 1) @(negedge clk);
            end
        end
    end

    task automatic send_number(input logic [2:0] kind, input logic [63:0] value);
        int gap;
        gap = quiet ? 0 : draw_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= kind;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_text();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
    endtask

    function automatic logic [63:0] random_value();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1, 2: v = v;
            3:       v = v >> $urandom_range(0, 63);
            4:       v = 64'($urandom_range(0, 20));
            5:       v = {v[63:32], 32'd0};
            6:       v = 64'd1 << $urandom_range(0, 63);
            7:       v = ~(64'd1 << $urandom_range(0, 63));
            8:       v = {v[63:32], 32'h8000_0000 + 32'($urandom_range(0, 3))};
            default: v = {v[63:32], 32'h7fff_ffff - 32'($urandom_range(0, 3))};
        endcase
        return v;
    endfunction

    initial
    begin
        logic [2:0] kind;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_number(ita_pkg::KIND_SDEC,  64'd0);
        send_number(ita_pkg::KIND_SDEC,  64'h0000_0000_8000_0000);
        send_number(ita_pkg::KIND_SDEC,  64'hffff_ffff_ffff_ffff);
        send_number(ita_pkg::KIND_SDEC,  64'h0000_0000_7fff_ffff);
        send_number(ita_pkg::KIND_SDEC,  64'd7);
        send_number(ita_pkg::KIND_UDEC,  64'h0000_0000_ffff_ffff);
        send_number(ita_pkg::KIND_UDEC,  64'hffff_ffff_0000_0000);
        send_number(ita_pkg::KIND_UDEC,  64'd1);
        send_number(ita_pkg::KIND_HEX_L, 64'h0000_0000_ffff_ffff);
        send_number(ita_pkg::KIND_HEX_L, 64'h1234_5678_abcd_ef01);
        send_number(ita_pkg::KIND_HEX_L, 64'hffff_ffff_0000_0000);
        send_number(ita_pkg::KIND_HEX_U, 64'h0000_0000_fedc_ba98);
        send_number(ita_pkg::KIND_HEX_U, 64'd10);
        send_number(ita_pkg::KIND_HEX_U, 64'd0);
        send_number(ita_pkg::KIND_PTR,   64'd0);
        send_number(ita_pkg::KIND_PTR,   64'hffff_ffff_ffff_ffff);
        send_number(ita_pkg::KIND_PTR,   64'd1);
        send_number(ita_pkg::KIND_PTR,   64'h8000_0000_0000_0000);
        send_number(ita_pkg::KIND_PTR,   64'h0000_0001_0000_0000);
        send_number(3'd5,                64'h0000_0000_8000_0000);
        send_number(3'd6,                64'd0);
        send_number(3'd7,                64'hffff_ffff_ffff_ffff);
        drain_text();

        for (int i = 0; i < 140; i++)
        begin
            quiet = (i >= 100 && i < 130);
            if ($urandom_range(0, 99) < 85)
                kind = 3'($urandom_range(0, 4));
            else
                kind = 3'($urandom_range(5, 7));
            send_number(kind, random_value());
            if (i == 80)
                drain_text();
        end
        quiet = 1'b0;

        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
